@@ hw/rtl/sorted_table_insert_delete_unit_macros.svh @@
// Assertion macros for the sorted table insert/delete unit.
`ifndef SORTED_TABLE_INSERT_DELETE_UNIT_MACROS_SVH
`define SORTED_TABLE_INSERT_DELETE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds in every cycle out of reset.
`define STID_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sorted table invariant violated");
// Check that a condition implies another one in the next cycle.
`define STID_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted table sequencing violated");
`else
`define STID_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define STID_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/stid_pkg.sv @@
// Shared types and constants for the sorted table insert/delete unit.
package stid_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic {
    FSM_IDLE   = 1'b0,
    FSM_UPDATE = 1'b1
  } fsm_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                      cmp;
    logic                      ins;
    logic                      del;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

@@ hw/rtl/stid_cell.sv @@
// One cell of the sorted chain: holds an entry, compares and shifts.
module stid_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  stid_pkg::cell_ctl_t                  ctl,
  input  logic signed [stid_pkg::VALUE_W-1:0]  lower_entry,
  input  logic                                 lower_valid,
  input  logic                                 lower_lt,
  input  logic signed [stid_pkg::VALUE_W-1:0]  upper_entry,
  input  logic                                 upper_valid,
  output logic signed [stid_pkg::VALUE_W-1:0]  entry,
  output logic                                 valid,
  output logic                                 lt,
  output logic                                 eq
);

  logic boundary;

  // The first cell not below the value is where an insert lands
  assign boundary = !lt && lower_lt;

  // Latch the compare results against the incoming value
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= valid && (entry < ctl.value);
      eq <= valid && (entry == ctl.value);
    end
  end

  // Shift up on insert, down on delete; cells below the value hold
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      entry <= boundary ? ctl.value : lower_entry;
    end else if (ctl.del && !lt) begin
      entry <= upper_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins && !lt) begin
      valid <= valid | lower_valid;
    end else if (ctl.del && !lt) begin
      valid <= upper_valid;
    end
  end

endmodule

@@ hw/rtl/sorted_table_insert_delete_unit.sv @@
// Sorted table insert/delete unit: a chain of compare-and-shift cells.
//
// Keeps up to TABLE_DEPTH distinct signed 32-bit values in ascending order.
// A request is taken when start is high and busy is low. All cells compare
// against the value when it is taken, the chain shifts in the update state
// that follows, and the result is shown with done high for exactly one cycle
// after that; busy holds off a new request only while the chain shifts.
// The result cannot be held off; sample it while done is high. Status tells
// inserted, deleted, duplicate ignored, not found or table full; position is
// the index touched (low bits, zero when nothing changed) and entry_count the
// fill after the request. No clearing pass is needed after reset.
module sorted_table_insert_delete_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic signed [stid_pkg::VALUE_W-1:0] value,
  output logic                                done,
  output logic [stid_pkg::STATUS_W-1:0]       status,
  output logic [stid_pkg::POS_W-1:0]          position,
  output logic [stid_pkg::COUNT_W-1:0]        entry_count
);

`include "sorted_table_insert_delete_unit_macros.svh"

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VW = stid_pkg::VALUE_W;

  stid_pkg::fsm_t    state, state_next;
  stid_pkg::cell_ctl_t ctl;
  logic              accept;
  logic              op_q;
  logic signed [VW-1:0] value_q;
  logic [CW-1:0]     count, count_next;

  logic signed [VW-1:0] entry_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_w, lt_w, eq_w, boundary;

  logic              found, full, do_ins, do_del;
  logic [IW-1:0]     pos_enc;
  stid_pkg::status_t status_next;
  logic [IW-1:0]     pos_next;

  assign accept = start && !busy;
  assign busy   = (state == stid_pkg::FSM_UPDATE);

  // Hold the request while the chain works on it
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= operation;
      value_q <= value;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stid_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      stid_pkg::FSM_IDLE: begin
        if (accept) state_next = stid_pkg::FSM_UPDATE;
      end
      stid_pkg::FSM_UPDATE: begin
        state_next = stid_pkg::FSM_IDLE;
      end
      default: state_next = stid_pkg::FSM_IDLE;
    endcase
  end

  // Decide the request from the latched compare results
  assign found    = |eq_w;
  assign full     = valid_w[TABLE_DEPTH-1];
  assign do_ins   = busy && (op_q == stid_pkg::OP_INSERT) && !found && !full;
  assign do_del   = busy && (op_q == stid_pkg::OP_DELETE) && found;
  assign boundary = ~lt_w & {lt_w[TABLE_DEPTH-2:0], 1'b1};

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (boundary[i]) pos_enc = pos_enc | IW'(i);
    end
  end

  always_comb begin
    if (op_q == stid_pkg::OP_DELETE) begin
      status_next = found ? stid_pkg::ST_DELETED : stid_pkg::ST_NOTFOUND;
    end else if (found) begin
      status_next = stid_pkg::ST_DUPLICATE;
    end else if (full) begin
      status_next = stid_pkg::ST_FULL;
    end else begin
      status_next = stid_pkg::ST_INSERTED;
    end
    pos_next = (do_ins || do_del) ? pos_enc : '0;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_del) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Broadcast to the chain: compare on accept, shift in the update cycle
  assign ctl.cmp   = accept;
  assign ctl.ins   = do_ins;
  assign ctl.del   = do_del;
  assign ctl.value = busy ? value_q : value;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic signed [VW-1:0] lower_entry, upper_entry;
    logic lower_valid, lower_lt, upper_valid;
    if (i == 0) begin : g_first
      assign lower_entry = value_q;
      assign lower_valid = 1'b1;
      assign lower_lt    = 1'b1;
    end else begin : g_mid_lo
      assign lower_entry = entry_w[i-1];
      assign lower_valid = valid_w[i-1];
      assign lower_lt    = lt_w[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign upper_entry = '0;
      assign upper_valid = 1'b0;
    end else begin : g_mid_hi
      assign upper_entry = entry_w[i+1];
      assign upper_valid = valid_w[i+1];
    end
    stid_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .lower_entry (lower_entry),
      .lower_valid (lower_valid),
      .lower_lt    (lower_lt),
      .upper_entry (upper_entry),
      .upper_valid (upper_valid),
      .entry       (entry_w[i]),
      .valid       (valid_w[i]),
      .lt          (lt_w[i]),
      .eq          (eq_w[i])
    );
  end

  // Register the result; done strobes for one cycle
  logic [IW-1:0] pos_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      status  <= status_next;
      pos_q   <= pos_next;
      count_q <= count_next;
    end
  end

  if (IW >= stid_pkg::POS_W) begin : g_pos_trunc
    assign position = pos_q[stid_pkg::POS_W-1:0];
  end else begin : g_pos_ext
    assign position = {{(stid_pkg::POS_W-IW){1'b0}}, pos_q};
  end

  if (CW >= stid_pkg::COUNT_W) begin : g_cnt_trunc
    assign entry_count = count_q[stid_pkg::COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign entry_count = {{(stid_pkg::COUNT_W-CW){1'b0}}, count_q};
  end

  // Occupied cells form a contiguous run from the bottom matching the count
  `STID_ASSERT_ALWAYS(a_valid_contig, clk, rst, (valid_w & ~{valid_w[TABLE_DEPTH-2:0], 1'b1}) == '0)
  `STID_ASSERT_ALWAYS(a_count_match, clk, rst, $countones(valid_w) == 32'(count))
  `STID_ASSERT_NEXT(a_done_follows, clk, rst, busy, done && !busy)

endmodule

@@ bench/tb_sorted_table_insert_delete_unit.sv @@
// Self-checking bench for the sorted table insert/delete unit.
module tb_sorted_table_insert_delete_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef logic signed [stid_pkg::VALUE_W-1:0] word_t;

  typedef struct {
    stid_pkg::op_t op;
    word_t         value;
    int unsigned   gap;
    bit            drain;
  } table_req_t;

  typedef struct {
    stid_pkg::status_t            status;
    logic [stid_pkg::POS_W-1:0]   position;
    logic [stid_pkg::COUNT_W-1:0] count;
  } table_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          operation = stid_pkg::OP_INSERT;
  word_t                         value = '0;
  logic                          busy;
  logic                          done;
  logic [stid_pkg::STATUS_W-1:0] status;
  logic [stid_pkg::POS_W-1:0]    position;
  logic [stid_pkg::COUNT_W-1:0]  entry_count;

  // Shadow copy of the table contents
  word_t       shadow_tbl [DEPTH];
  int unsigned shadow_fill = 0;

  table_req_t    request_queue[$];
  table_result_t pending_results[$];
  int unsigned   err_count = 0;
  int unsigned   idle_cycles = 0;
  logic          req_taken = 1'b0;

  // Driver-side staging
  table_req_t  staged;
  bit          staged_valid = 1'b0;
  int unsigned gap_left = 0;

  sorted_table_insert_delete_unit #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .value       (value),
    .done        (done),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_request(stid_pkg::op_t op, word_t v, int unsigned gap, bit drain);
    table_req_t r;
    r.op    = op;
    r.value = v;
    r.gap   = gap;
    r.drain = drain;
    request_queue.push_back(r);
  endtask

  // Apply one request to the shadow table and work out its result
  function automatic table_result_t apply_to_shadow(stid_pkg::op_t op, word_t v);
    table_result_t r;
    int unsigned   lb;
    int unsigned   k;
    bit            hit;
    lb = 0;
    while (lb < shadow_fill && shadow_tbl[lb] < v) lb++;
    hit = (lb < shadow_fill) && (shadow_tbl[lb] == v);
    r.position = '0;
    if (op == stid_pkg::OP_INSERT) begin
      if (hit) begin
        r.status = stid_pkg::ST_DUPLICATE;
      end else if (shadow_fill >= DEPTH) begin
        r.status = stid_pkg::ST_FULL;
      end else begin
        for (k = shadow_fill; k > lb; k--) shadow_tbl[k] = shadow_tbl[k-1];
        shadow_tbl[lb] = v;
        shadow_fill++;
        r.status   = stid_pkg::ST_INSERTED;
        r.position = stid_pkg::POS_W'(lb);
      end
    end else begin
      if (!hit) begin
        r.status = stid_pkg::ST_NOTFOUND;
      end else begin
        for (k = lb; k + 1 < shadow_fill; k++) shadow_tbl[k] = shadow_tbl[k+1];
        shadow_fill--;
        r.status   = stid_pkg::ST_DELETED;
        r.position = stid_pkg::POS_W'(lb);
      end
    end
    r.count = stid_pkg::COUNT_W'(shadow_fill);
    return r;
  endfunction

  // Drive requests at the falling edge; hold the current one until it is taken
  always @(negedge clk) begin
    if (!rst && !(start && !req_taken)) begin
      if (!staged_valid && request_queue.size() != 0) begin
        staged       = request_queue.pop_front();
        staged_valid = 1'b1;
        gap_left     = staged.gap;
      end
      if (staged_valid && gap_left == 0 &&
          !(staged.drain && pending_results.size() != 0)) begin
        operation <= staged.op;
        value     <= staged.value;
        start     <= 1'b1;
        staged_valid = 1'b0;
      end else begin
        if (gap_left != 0) gap_left--;
        start <= 1'b0;
      end
    end
  end

  // Check results, predict accepted requests and watch for a stall
  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (rst) begin
      req_taken   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (done) begin
        got.status   = stid_pkg::status_t'(status);
        got.position = position;
        got.count    = entry_count;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: status %0d pos %0d count %0d",
                                    status, position, entry_count));
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d", status, want.status));
          if (got.position !== want.position)
            report_mismatch($sformatf("position got %0d expected %0d",
                                      position, want.position));
          if (got.count !== want.count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      entry_count, want.count));
        end
      end
      if (start && !busy)
        pending_results.push_back(apply_to_shadow(stid_pkg::op_t'(operation), value));
      req_taken <= start && !busy;
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Build the request list, release reset and wait for the run to drain
  initial begin
    word_t         pool [POOL_SIZE];
    int unsigned   n;
    int unsigned   insert_bias;
    int unsigned   gap;
    stid_pkg::op_t op;
    word_t         v;

    // Directed: empty table, extremes, duplicates, absent values
    add_request(stid_pkg::OP_DELETE, 32'sd7, 0, 1'b0);
    add_request(stid_pkg::OP_INSERT, 32'sd0, 0, 1'b0);
    add_request(stid_pkg::OP_INSERT, 32'sh7FFF_FFFF, 3, 1'b0);
    add_request(stid_pkg::OP_INSERT, 32'sh8000_0000, 0, 1'b0);
    add_request(stid_pkg::OP_INSERT, -32'sd1, 0, 1'b0);
    add_request(stid_pkg::OP_INSERT, 32'sd1, 1, 1'b0);
    add_request(stid_pkg::OP_INSERT, 32'sd0, 0, 1'b0);
    add_request(stid_pkg::OP_DELETE, 32'sd5, 0, 1'b0);
    add_request(stid_pkg::OP_DELETE, 32'sh8000_0000, 0, 1'b0);
    add_request(stid_pkg::OP_DELETE, 32'sh7FFF_FFFF, 2, 1'b1);
    // Fill to the top, each new value landing at the head
    for (n = 1; n <= DEPTH - 3; n++)
      add_request(stid_pkg::OP_INSERT, -word_t'(n * 1000), 0, 1'b0);
    add_request(stid_pkg::OP_INSERT, 32'sd7, 0, 1'b0);
    add_request(stid_pkg::OP_INSERT, 32'sd0, 0, 1'b0);

    // Value pool: extremes plus clustered and wide random values
    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7FFF_FFFF;
    pool[2] = 32'sd0;
    pool[3] = -32'sd1;
    for (n = 4; n < POOL_SIZE; n++)
      pool[n] = (n % 2 == 0) ? word_t'($urandom_range(0, 40)) - 32'sd20 : word_t'($urandom);

    // Random: alternate insert-heavy and delete-heavy phases over the pool
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      insert_bias = ((n / 48) % 2 == 0) ? 80 : 25;
      op  = ($urandom_range(0, 99) < insert_bias) ? stid_pkg::OP_INSERT
                                                  : stid_pkg::OP_DELETE;
      v   = ($urandom_range(0, 99) < 70) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : word_t'($urandom);
      gap = ((n / 64) % 4 == 3) ? 0 : $urandom_range(0, 10);
      add_request(op, v, gap, (n % 100 == 0));
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (request_queue.size() != 0 || staged_valid || start) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
